>>> rtl/vna_pkg.sv
// shared types and constants of the vertex normal accumulator
package vna_pkg;

    localparam int IDX_W = 14;
    localparam int POS_W = 16;
    localparam int NRM_W = 16;
    localparam int ACC_W = 24;
    localparam int VEC_W = 35;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TRI   = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;

    localparam logic NORM_SRC_CROSS = 1'b0;
    localparam logic NORM_SRC_SUM   = 1'b1;

    localparam logic [14:0] ONE_Q14 = 15'd16384;

    typedef struct packed {
        logic [1:0]              op;
        logic [IDX_W-1:0]        vertex_index;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } item_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic                    saturated;
    } result_t;

    typedef struct packed {
        logic       capture;
        logic       clr_step;
        logic       pos_wr;
        logic       pos_rd;
        logic [1:0] pos_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       edge_load;
        logic       cross_step;
        logic       norm_start;
        logic       norm_src;
        logic       acc_rd;
        logic       acc_wr;
        logic       sum_rd;
        logic       res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic tri_ok;
        logic cross_done;
        logic norm_done;
        logic norm_nonzero;
        logic acc_last;
    } dp_sts_t;

endpackage

>>> rtl/vna_stream_if.sv
// valid/ready channel carrying one payload per transaction
interface vna_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/vertex_normal_accumulator.sv
// top level of the vertex normal accumulator
//
// items carries one request per transaction: clear sums, write a vertex
// position, add a triangle, or read a vertex normal. results returns exactly
// one transaction per request, in order; normals are nonzero only for reads,
// saturated only for triangles whose accumulation clipped.
// one request is worked on at a time; items.ready is high only while idle.
// steps per request, accept to result valid:
//   write: position write; out-of-range triangle: result only
//   triangle: corner reads, edges, cross product, normalizer, then the corner
//     sums unless the normal is zero; read: sum read, normalizer; normalizer:
//     range shift one bit a cycle, three squares on one multiplier, root
//     (one digit a cycle), three 15-bit restoring divides
//   clear: a sweep zeroing one sum entry per cycle
// after reset the same sweep runs with items.ready low.
// a stalled result waits in the output register; the next request is still
// accepted and its result is held until the register frees.
module vertex_normal_accumulator #(
    parameter int VERTICES = 16384
) (
    input logic              clk,
    input logic              rst_n,
    vna_stream_if.sink       items,
    vna_stream_if.source     results
);

    vna_pkg::dp_cmd_t cmd;
    vna_pkg::dp_sts_t sts;
    vna_pkg::result_t res;

    vna_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_op     (items.data.op),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    vna_dp #(
        .VERTICES (VERTICES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .in_item (items.data),
        .res     (res)
    );

    assign results.data = res;

    // sequential block: busy right after taking a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.ready |=> !items.ready)
        else $error("request accepted while busy");

    // clipping is only reported by triangles, which carry no normal
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.saturated |->
            results.data.normal_x == '0 && results.data.normal_y == '0 &&
            results.data.normal_z == '0)
        else $error("saturated flag on a read result");

    // unit normal components never exceed one in q1.14
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |->
            results.data.normal_x <= 16'sd16384 && results.data.normal_x >= -16'sd16384 &&
            results.data.normal_y <= 16'sd16384 && results.data.normal_y >= -16'sd16384 &&
            results.data.normal_z <= 16'sd16384 && results.data.normal_z >= -16'sd16384)
        else $error("normal component out of range");

endmodule

>>> rtl/vna_norm.sv
// iterative vector normalizer to q1.14: shift, square sum, square root, divide
module vna_norm (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [vna_pkg::VEC_W-1:0]   vec [3],
    output logic                               done,
    output logic                               nonzero,
    output logic signed [vna_pkg::NRM_W-1:0]   res [3]
);

    typedef enum logic [5:0] {
        N_IDLE  = 6'b000001,
        N_SHIFT = 6'b000010,
        N_SQ    = 6'b000100,
        N_SQRT  = 6'b001000,
        N_DIV   = 6'b010000,
        N_DONE  = 6'b100000
    } norm_state_t;

    norm_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  comp_reg, comp_next;

    logic [vna_pkg::VEC_W-1:0]      m_reg [3];
    logic                           neg_reg [3];
    logic [39:0]                    prod_reg;
    logic [41:0]                    sq_reg;
    logic [20:0]                    root_reg;
    logic [22:0]                    rem_reg;
    logic [20:0]                    r_reg;
    logic [14:0]                    nlo_reg;
    logic [13:0]                    q_reg;
    logic signed [vna_pkg::NRM_W-1:0] res_reg [3];
    logic                           nonzero_reg;

    logic                           any_big, any_top, all_zero;
    logic [19:0]                    m_sq_sel, m_div_sel;
    logic [24:0]                    remw, trial;
    logic                           sq_ge;
    logic [vna_pkg::VEC_W-1:0]      n_full;
    logic [21:0]                    rw, rdiff;
    logic                           dge;
    logic [14:0]                    qn, qc;
    logic signed [vna_pkg::NRM_W-1:0] q_signed;

    always_comb
    begin
        any_big  = (|m_reg[0][34:20]) | (|m_reg[1][34:20]) | (|m_reg[2][34:20]);
        any_top  = m_reg[0][19] | m_reg[1][19] | m_reg[2][19];
        all_zero = (m_reg[0] == '0) && (m_reg[1] == '0) && (m_reg[2] == '0);
        m_sq_sel  = (cnt_reg[1:0] == 2'd3) ? 20'd0 : m_reg[cnt_reg[1:0]][19:0];
        m_div_sel = (comp_reg == 2'd3) ? 20'd0 : m_reg[comp_reg][19:0];
        // one root digit per cycle
        remw  = {rem_reg, sq_reg[41:40]};
        trial = {2'b00, root_reg, 2'b01};
        sq_ge = (remw >= trial);
        // rounded numerator m * 2^14 + len / 2
        n_full = {1'b0, m_div_sel, 14'd0} + vna_pkg::VEC_W'(root_reg[20:1]);
        rw    = {r_reg, nlo_reg[14]};
        dge   = (rw >= {1'b0, root_reg});
        rdiff = rw - {1'b0, root_reg};
        qn    = {q_reg, dge};
        qc    = (qn > vna_pkg::ONE_Q14) ? vna_pkg::ONE_Q14 : qn;
        q_signed = (comp_reg != 2'd3 && neg_reg[comp_reg]) ? -(16'(qc)) : 16'(qc);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    state_next = N_SHIFT;
                end
            end
            N_SHIFT:
            begin
                if (all_zero)
                begin
                    state_next = N_DONE;
                end
                else if (!any_big && any_top)
                begin
                    state_next = N_SQ;
                    cnt_next   = '0;
                end
            end
            N_SQ:
            begin
                if (cnt_reg == 5'd3)
                begin
                    state_next = N_SQRT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            N_SQRT:
            begin
                if (cnt_reg == 5'd20)
                begin
                    state_next = N_DIV;
                    cnt_next   = '0;
                    comp_next  = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            N_DIV:
            begin
                if (cnt_reg == 5'd15)
                begin
                    cnt_next = '0;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = N_DONE;
                    end
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            N_DONE:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= vec[i][vna_pkg::VEC_W-1];
                        m_reg[i]   <= vec[i][vna_pkg::VEC_W-1] ? vna_pkg::VEC_W'(-vec[i])
                                                               : vna_pkg::VEC_W'(vec[i]);
                        res_reg[i] <= '0;
                    end
                    nonzero_reg <= 1'b0;
                end
            end
            N_SHIFT:
            begin
                if (!all_zero)
                begin
                    if (any_big)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] >> 1;
                        end
                    end
                    else if (!any_top)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] << 1;
                        end
                    end
                    else
                    begin
                        sq_reg      <= '0;
                        nonzero_reg <= 1'b1;
                    end
                end
            end
            N_SQ:
            begin
                prod_reg <= m_sq_sel * m_sq_sel;
                if (cnt_reg != 5'd0)
                begin
                    sq_reg <= sq_reg + {2'b00, prod_reg};
                end
                root_reg <= '0;
                rem_reg  <= '0;
            end
            N_SQRT:
            begin
                rem_reg  <= sq_ge ? 23'(remw - trial) : remw[22:0];
                root_reg <= {root_reg[19:0], sq_ge};
                sq_reg   <= {sq_reg[39:0], 2'b00};
            end
            N_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    r_reg   <= {1'b0, n_full[34:15]};
                    nlo_reg <= n_full[14:0];
                    q_reg   <= '0;
                end
                else
                begin
                    r_reg   <= dge ? rdiff[20:0] : rw[20:0];
                    nlo_reg <= {nlo_reg[13:0], 1'b0};
                    q_reg   <= qn[13:0];
                    if (cnt_reg == 5'd15 && comp_reg != 2'd3)
                    begin
                        res_reg[comp_reg] <= q_signed;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done    = (state_reg == N_DONE);
    assign nonzero = nonzero_reg;
    assign res     = res_reg;

endmodule

>>> rtl/vna_dp.sv
// datapath: position and sum memories, cross product, accumulation, result register
module vna_dp #(
    parameter int VERTICES = 16384
) (
    input  logic             clk,
    input  logic             rst_n,
    input  vna_pkg::dp_cmd_t cmd,
    output vna_pkg::dp_sts_t sts,
    input  vna_pkg::item_t   in_item,
    output vna_pkg::result_t res
);

    localparam int AW = $clog2(VERTICES);
    localparam int PW = 3 * vna_pkg::POS_W;
    localparam int SW = 3 * vna_pkg::ACC_W;

    vna_pkg::item_t   item_reg;
    vna_pkg::result_t res_reg;

    logic [PW-1:0] pos_mem [VERTICES];
    logic [PW-1:0] pos_rd_reg;
    logic [PW-1:0] p_reg [3];
    logic [SW-1:0] sum_mem [VERTICES];
    logic [SW-1:0] sum_rd_reg;

    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e2_reg [3];
    logic signed [33:0] prod_reg;
    logic [2:0]         prod_idx_reg;
    logic [2:0]         mul_cnt_reg;
    logic signed [vna_pkg::VEC_W-1:0] cross_reg [3];

    logic [1:0]    acc_cnt_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          sat_reg;

    logic [vna_pkg::IDX_W-1:0] corner [3];
    logic                      idx_ok;
    logic [AW-1:0]             acc_addr, sum_rd_addr;
    logic signed [16:0]        mul_a, mul_b;
    logic signed [33:0]        prod_c;
    logic [1:0]                prod_comp;
    logic signed [vna_pkg::VEC_W-1:0] norm_vec [3];
    logic                      norm_done, norm_nonzero;
    logic signed [vna_pkg::NRM_W-1:0] norm_res [3];
    logic [24:0]               add_x, add_y, add_z;
    logic [SW-1:0]             acc_new;

    function automatic logic in_range(logic [vna_pkg::IDX_W-1:0] i);
        return ({18'd0, i} < 32'(VERTICES));
    endfunction

    function automatic logic [AW-1:0] to_addr(logic [vna_pkg::IDX_W-1:0] i);
        return AW'(i);
    endfunction

    function automatic logic signed [16:0] pdiff(logic [15:0] p, logic [15:0] q);
        return {p[15], p} - {q[15], q};
    endfunction

    // returns {clipped, value}
    function automatic logic [24:0] sat_add(logic [23:0] s, logic [15:0] f);
        logic signed [24:0] t;
        t = $signed({s[23], s}) + $signed({{9{f[15]}}, f});
        if (t > 25'sd8388607)
            return {1'b1, 24'h7FFFFF};
        else if (t < -25'sd8388608)
            return {1'b1, 24'h800000};
        else
            return {1'b0, t[23:0]};
    endfunction

    assign corner[0] = item_reg.corner_a;
    assign corner[1] = item_reg.corner_b;
    assign corner[2] = item_reg.corner_c;
    assign idx_ok    = in_range(item_reg.vertex_index);
    assign acc_addr  = (acc_cnt_reg == 2'd3) ? '0 : to_addr(corner[acc_cnt_reg]);
    assign sum_rd_addr = cmd.acc_rd ? acc_addr : to_addr(item_reg.vertex_index);

    // operand schedule of the cross product (b - a) x (c - a)
    always_comb
    begin
        case (mul_cnt_reg)
            3'd0:    begin mul_a = e1_reg[1]; mul_b = e2_reg[2]; end
            3'd1:    begin mul_a = e1_reg[2]; mul_b = e2_reg[1]; end
            3'd2:    begin mul_a = e1_reg[2]; mul_b = e2_reg[0]; end
            3'd3:    begin mul_a = e1_reg[0]; mul_b = e2_reg[2]; end
            3'd4:    begin mul_a = e1_reg[0]; mul_b = e2_reg[1]; end
            3'd5:    begin mul_a = e1_reg[1]; mul_b = e2_reg[0]; end
            default: begin mul_a = '0;        mul_b = '0;        end
        endcase
        prod_c    = mul_a * mul_b;
        prod_comp = prod_idx_reg[2:1];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cmd.norm_src == vna_pkg::NORM_SRC_CROSS)
                norm_vec[i] = cross_reg[i];
            else if (idx_ok)
                norm_vec[i] = vna_pkg::VEC_W'($signed(sum_rd_reg[SW-1-24*i -: 24]));
            else
                norm_vec[i] = '0;
        end
        add_x   = sat_add(sum_rd_reg[71:48], norm_res[0]);
        add_y   = sat_add(sum_rd_reg[47:24], norm_res[1]);
        add_z   = sat_add(sum_rd_reg[23:0],  norm_res[2]);
        acc_new = {add_x[23:0], add_y[23:0], add_z[23:0]};
    end

    vna_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.norm_start),
        .vec     (norm_vec),
        .done    (norm_done),
        .nonzero (norm_nonzero),
        .res     (norm_res)
    );

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.pos_wr && idx_ok)
        begin
            pos_mem[to_addr(item_reg.vertex_index)] <= {item_reg.pos_x, item_reg.pos_y,
                                                       item_reg.pos_z};
        end
        if (cmd.pos_rd)
        begin
            pos_rd_reg <= pos_mem[(cmd.pos_sel == 2'd3) ? '0 : to_addr(corner[cmd.pos_sel])];
        end
        if (cmd.clr_step)
        begin
            sum_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.acc_wr)
        begin
            sum_mem[acc_addr] <= acc_new;
        end
        if (cmd.sum_rd || cmd.acc_rd)
        begin
            sum_rd_reg <= sum_mem[sum_rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        if (cmd.cap_en && cmd.cap_sel != 2'd3)
        begin
            p_reg[cmd.cap_sel] <= pos_rd_reg;
        end
        if (cmd.edge_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= pdiff(p_reg[1][PW-1-16*i -: 16], p_reg[0][PW-1-16*i -: 16]);
                e2_reg[i] <= pdiff(p_reg[2][PW-1-16*i -: 16], p_reg[0][PW-1-16*i -: 16]);
            end
        end
        if (cmd.cross_step)
        begin
            if (mul_cnt_reg != 3'd6)
            begin
                prod_reg     <= prod_c;
                prod_idx_reg <= mul_cnt_reg;
            end
            if (mul_cnt_reg != 3'd0 && prod_comp != 2'd3)
            begin
                if (!prod_idx_reg[0])
                    cross_reg[prod_comp] <= vna_pkg::VEC_W'(prod_reg);
                else
                    cross_reg[prod_comp] <= cross_reg[prod_comp] - vna_pkg::VEC_W'(prod_reg);
            end
        end
        if (cmd.res_load)
        begin
            if (item_reg.op == vna_pkg::OP_READ)
            begin
                res_reg.normal_x <= norm_res[0];
                res_reg.normal_y <= norm_res[1];
                res_reg.normal_z <= norm_res[2];
            end
            else
            begin
                res_reg.normal_x <= '0;
                res_reg.normal_y <= '0;
                res_reg.normal_z <= '0;
            end
            res_reg.saturated <= (item_reg.op == vna_pkg::OP_TRI) && sat_reg;
        end
    end

    // counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_cnt_reg <= '0;
            acc_cnt_reg <= '0;
            clr_cnt_reg <= '0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.edge_load)
                mul_cnt_reg <= '0;
            else if (cmd.cross_step && mul_cnt_reg != 3'd6)
                mul_cnt_reg <= mul_cnt_reg + 3'd1;

            if (cmd.capture)
                acc_cnt_reg <= '0;
            else if (cmd.acc_wr)
                acc_cnt_reg <= acc_cnt_reg + 2'd1;

            if (cmd.clr_step)
                clr_cnt_reg <= sts.clr_last ? '0 : clr_cnt_reg + AW'(1);

            if (cmd.capture)
                sat_reg <= 1'b0;
            else if (cmd.acc_wr)
                sat_reg <= sat_reg | add_x[24] | add_y[24] | add_z[24];
        end
    end

    always_comb
    begin
        sts.clr_last     = (clr_cnt_reg == AW'(VERTICES - 1));
        sts.tri_ok       = in_range(corner[0]) && in_range(corner[1]) && in_range(corner[2]);
        sts.cross_done   = (mul_cnt_reg == 3'd6);
        sts.norm_done    = norm_done;
        sts.norm_nonzero = norm_nonzero;
        sts.acc_last     = (acc_cnt_reg == vna_pkg::CORNER_C);
    end

    assign res = res_reg;

endmodule

>>> rtl/vna_ctrl.sv
// controller: sequences each transaction through the datapath
module vna_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_op,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output vna_pkg::dp_cmd_t cmd,
    input  vna_pkg::dp_sts_t sts
);

    typedef enum logic [16:0] {
        S_CLEAR = 17'b00000000000000001,
        S_IDLE  = 17'b00000000000000010,
        S_POSW  = 17'b00000000000000100,
        S_TRA   = 17'b00000000000001000,
        S_TRB   = 17'b00000000000010000,
        S_TRC   = 17'b00000000000100000,
        S_TRW   = 17'b00000000001000000,
        S_EDGE  = 17'b00000000010000000,
        S_CROSS = 17'b00000000100000000,
        S_TNORM = 17'b00000001000000000,
        S_TWAIT = 17'b00000010000000000,
        S_ACCR  = 17'b00000100000000000,
        S_ACCW  = 17'b00001000000000000,
        S_RRD   = 17'b00010000000000000,
        S_RNORM = 17'b00100000000000000,
        S_RWAIT = 17'b01000000000000000,
        S_RESP  = 17'b10000000000000000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        reply_reg, reply_next;
    logic        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        reply_next     = reply_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = reply_reg ? S_RESP : S_IDLE;
                    reply_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (in_op)
                        vna_pkg::OP_CLEAR:
                        begin
                            state_next = S_CLEAR;
                            reply_next = 1'b1;
                        end
                        vna_pkg::OP_WRITE: state_next = S_POSW;
                        vna_pkg::OP_TRI:   state_next = S_TRA;
                        default:           state_next = S_RRD;
                    endcase
                end
            end
            S_POSW:
            begin
                cmd.pos_wr = 1'b1;
                state_next = S_RESP;
            end
            S_TRA:
            begin
                if (sts.tri_ok)
                begin
                    cmd.pos_rd  = 1'b1;
                    cmd.pos_sel = vna_pkg::CORNER_A;
                    state_next  = S_TRB;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_TRB:
            begin
                cmd.pos_rd  = 1'b1;
                cmd.pos_sel = vna_pkg::CORNER_B;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = vna_pkg::CORNER_A;
                state_next  = S_TRC;
            end
            S_TRC:
            begin
                cmd.pos_rd  = 1'b1;
                cmd.pos_sel = vna_pkg::CORNER_C;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = vna_pkg::CORNER_B;
                state_next  = S_TRW;
            end
            S_TRW:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = vna_pkg::CORNER_C;
                state_next  = S_EDGE;
            end
            S_EDGE:
            begin
                cmd.edge_load = 1'b1;
                state_next    = S_CROSS;
            end
            S_CROSS:
            begin
                cmd.cross_step = 1'b1;
                if (sts.cross_done)
                    state_next = S_TNORM;
            end
            S_TNORM:
            begin
                cmd.norm_start = 1'b1;
                cmd.norm_src   = vna_pkg::NORM_SRC_CROSS;
                state_next     = S_TWAIT;
            end
            S_TWAIT:
            begin
                if (sts.norm_done)
                    state_next = sts.norm_nonzero ? S_ACCR : S_RESP;
            end
            S_ACCR:
            begin
                cmd.acc_rd = 1'b1;
                state_next = S_ACCW;
            end
            S_ACCW:
            begin
                cmd.acc_wr = 1'b1;
                state_next = sts.acc_last ? S_RESP : S_ACCR;
            end
            S_RRD:
            begin
                cmd.sum_rd = 1'b1;
                state_next = S_RNORM;
            end
            S_RNORM:
            begin
                cmd.norm_start = 1'b1;
                cmd.norm_src   = vna_pkg::NORM_SRC_SUM;
                state_next     = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (sts.norm_done)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                // load only once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            reply_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            reply_reg     <= reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
